// ===== rtl/core/fqr_pkg.sv =====
// shared types and constants for the fifo queue with remove-at
package fqr_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_REM = 2'd2
    } t_action;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== rtl/core/fqr_cell.sv =====
// one storage cell of the queue chain
module fqr_cell
    import fqr_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_value_in,
    input  logic [DATA_W-1:0] i_nbr,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift) begin
            n_data = i_nbr;
        end else if (i_ctl.wr) begin
            n_data = i_value_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/fifo_queue_with_remove_at_core.sv =====
// Ordered queue of signed 32-bit values with dequeue and remove-at-position.
// Input channel: i_in_valid / o_in_ready carry one request per beat:
//   i_action (enqueue, dequeue, remove at position), i_value_in, i_position.
// Output channel: o_out_valid / i_out_ready carry one result per request:
//   o_ok, o_value_out (removed value, zero otherwise), o_count (length after).
// Storage is a row of DEPTH cells, head in cell 0. Enqueue writes the cell at
// the current length; a removal makes every cell at or past the index load its
// upper neighbor in the same cycle.
// The result is registered and shows in the cycle after the input beat.
// Throughput: one request per cycle while the output is taken; the removed value
// is picked by an index compare in every cell.
// The output register is refilled in the same cycle it is taken, so a request
// is accepted whenever the result register is empty or being drained.
// When the receiver stalls, the result holds and o_in_ready drops.
// Reset empties the queue and clears the output valid; stored values are
// left as they are and never read before being written.
module fifo_queue_with_remove_at_core
    import fqr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic signed [DATA_W-1:0] i_value_in,
    input  logic [POS_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_ok,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [CNT_W-1:0]         o_count
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (OCC_W > POS_W) ? OCC_W : POS_W;
    localparam int XW    = (OCC_W > CNT_W) ? OCC_W : CNT_W;

    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;
    logic              r_out_valid;
    logic              r_ok;
    logic [DATA_W-1:0] r_value_out;
    logic [CNT_W-1:0]  r_count;

    logic              w_fire;
    logic              w_enq;
    logic              w_rem;
    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  w_occ_x;
    logic [DATA_W-1:0] w_sel_val;
    logic [XW-1:0]     w_cnt_x;
    logic [DATA_W-1:0] w_data [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_occ_x    = IDX_W'(r_occ);

    always_comb begin
        w_enq = 1'b0;
        w_rem = 1'b0;
        w_idx = '0;
        case (t_action'(i_action))
            ACT_ENQ: begin
                w_enq = w_occ_x < IDX_W'(DEPTH);
            end
            ACT_DEQ: begin
                w_rem = r_occ != '0;
            end
            ACT_REM: begin
                w_idx = IDX_W'(i_position);
                w_rem = IDX_W'(i_position) < w_occ_x;
            end
            default: begin
                w_enq = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl         w_ctl;
        logic [DATA_W-1:0] w_nbr;

        assign w_ctl.wr    = w_fire && w_enq && (w_occ_x == IDX_W'(g));
        assign w_ctl.shift = w_fire && w_rem && (IDX_W'(g) >= w_idx);

        if (g == DEPTH - 1) begin : g_last
            // nothing above the last cell: it keeps its stale value
            assign w_nbr = w_data[g];
        end else begin : g_mid
            assign w_nbr = w_data[g + 1];
        end

        fqr_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_value_in (i_value_in),
            .i_nbr      (w_nbr),
            .o_data     (w_data[g])
        );
    end

    // one-hot pick of the entry being removed
    always_comb begin
        w_sel_val = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_idx == IDX_W'(k)) begin
                w_sel_val = w_sel_val | w_data[k];
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (w_enq) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (w_rem) begin
            n_occ = r_occ - OCC_W'(1);
        end
    end

    assign w_cnt_x = XW'(n_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ok        <= w_enq || w_rem;
            r_value_out <= w_rem ? w_sel_val : '0;
            r_count     <= w_cnt_x[CNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_value_out = r_value_out;
    assign o_count     = r_count;

endmodule

// ===== rtl/core/fqr_checker.sv =====
// port-level checks for the fifo queue with remove-at, bound to the top level
module fqr_checker
    import fqr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_ok,
    input logic signed [DATA_W-1:0] o_value_out,
    input logic [CNT_W-1:0]         o_count
);

    // an accepted request always shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result after accepted request");

    // a stalled result beat stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ok)
            && $stable(o_value_out) && $stable(o_count))
        else $error("result changed while stalled");

    // failed requests never return a value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_value_out == '0)
        else $error("nonzero value on failed request");

    // length never exceeds the store when it fits the count field
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DEPTH < 32) |-> 32'(o_count) <= 32'(DEPTH))
        else $error("count beyond depth");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind fifo_queue_with_remove_at_core fqr_checker #(.DEPTH(DEPTH)) u_fqr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ok        (o_ok),
    .o_value_out (o_value_out),
    .o_count     (o_count)
);
